>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
// Each macro places one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion of an implication sampled on the rising clock edge.
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/core/rmq_pkg.sv
// Package for the rotation matrix to quaternion block.
// Holds the case codes and the per-item control struct; no dependencies.
`default_nettype none
package rmq_pkg;
  // Which component is taken from the square root.
  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;

  // Control carried along the cell chain with each item.
  typedef struct packed {
    logic vld;
    sel_t sel;
  } ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/rmq_sqrt_cell.sv
// One cell of the square root chain: retires one result bit per cycle.
// Depends on rmq_pkg for the control struct.
`default_nettype none
module rmq_sqrt_cell #(
  parameter int RW = 40,
  parameter int DW = 18,
  parameter int K  = 0
) (
  input  wire logic                 clk,
  input  rmq_pkg::ctl_t             ctl_i,
  input  wire logic [RW-1:0]        rem_i,
  input  wire logic [RW-1:0]        res_i,
  input  wire logic signed [DW-1:0] d0_i,
  input  wire logic signed [DW-1:0] d1_i,
  input  wire logic signed [DW-1:0] d2_i,
  output rmq_pkg::ctl_t             ctl_o,
  output logic [RW-1:0]             rem_o,
  output logic [RW-1:0]             res_o,
  output logic signed [DW-1:0]      d0_o,
  output logic signed [DW-1:0]      d1_o,
  output logic signed [DW-1:0]      d2_o
);
  import rmq_pkg::*;

  localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (2*K);

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_nxt;
  logic [RW-1:0] res_nxt;

  // Restoring step of the digit-by-digit root.
  always_comb begin
    trial = res_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt = rem_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      rem_nxt = rem_i;
      res_nxt = res_i >> 1;
    end
  end

  // Payload registers move to the next cell every cycle.
  always_ff @(posedge clk) begin
    ctl_o <= ctl_i;
    rem_o <= rem_nxt;
    res_o <= res_nxt;
    d0_o  <= d0_i;
    d1_o  <= d1_i;
    d2_o  <= d2_i;
  end
endmodule
`default_nettype wire

>>> rtl/core/rmq_div_cell.sv
// One cell of the divider chain: retires one quotient bit per lane per cycle.
// Depends on rmq_pkg for the control struct.
`default_nettype none
module rmq_div_cell #(
  parameter int NW = 48,
  parameter int SW = 20,
  parameter int K  = 0
) (
  input  wire logic          clk,
  input  rmq_pkg::ctl_t      ctl_i,
  input  wire logic [SW-1:0] s_i,
  input  wire logic [2:0]    neg_i,
  input  wire logic [NW-1:0] n0_i,
  input  wire logic [NW-1:0] n1_i,
  input  wire logic [NW-1:0] n2_i,
  input  wire logic [NW-1:0] q0_i,
  input  wire logic [NW-1:0] q1_i,
  input  wire logic [NW-1:0] q2_i,
  output rmq_pkg::ctl_t      ctl_o,
  output logic [SW-1:0]      s_o,
  output logic [2:0]         neg_o,
  output logic [NW-1:0]      n0_o,
  output logic [NW-1:0]      n1_o,
  output logic [NW-1:0]      n2_o,
  output logic [NW-1:0]      q0_o,
  output logic [NW-1:0]      q1_o,
  output logic [NW-1:0]      q2_o
);
  import rmq_pkg::*;

  logic [NW+SW:0] dsh;
  logic [NW-1:0] n_in [3];
  logic [NW-1:0] q_in [3];
  logic [NW-1:0] n_nx [3];
  logic [NW-1:0] q_nx [3];

  // Divisor 2*s shifted to bit position K.
  assign dsh = {{NW{1'b0}}, s_i, 1'b0} << K;
  assign n_in[0] = n0_i;
  assign n_in[1] = n1_i;
  assign n_in[2] = n2_i;
  assign q_in[0] = q0_i;
  assign q_in[1] = q1_i;
  assign q_in[2] = q2_i;

  // Restoring subtract in each of the three lanes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ({{(SW+1){1'b0}}, n_in[i]} >= dsh) begin
        n_nx[i] = n_in[i] - dsh[NW-1:0];
        q_nx[i] = q_in[i] | ({{(NW-1){1'b0}}, 1'b1} << K);
      end else begin
        n_nx[i] = n_in[i];
        q_nx[i] = q_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    ctl_o <= ctl_i;
    s_o   <= s_i;
    neg_o <= neg_i;
    n0_o  <= n_nx[0];
    n1_o  <= n_nx[1];
    n2_o  <= n_nx[2];
    q0_o  <= q_nx[0];
    q1_o  <= q_nx[1];
    q2_o  <= q_nx[2];
  end
endmodule
`default_nettype wire

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter (Shepperd's method), fixed point.
// Input channel: raise start with the nine matrix elements in_m00..in_m22;
// the item is taken on any edge where start is high and busy is low.
// busy is always low: the block takes one item every clock cycle.
// Result channel: out_valid is high for exactly one cycle with qx,qy,qz,qw.
// The receiver cannot stall; results must be taken in the cycle shown.
// Pipeline: input register, stage 1 register, (W+F+4)/2 root cells, (W+F+4)
// divider cells and the output register, in that order; one root bit per
// root cell, one quotient bit per divider cell, three lanes in parallel.
// With W=16, F=14 this is 17 root cells and 34 divider cells.
// Throughput: one item per cycle, results in the order items arrived.
// Reset (rst_n low, synchronous) clears the valid bits of every cell, so
// items in flight are dropped; payload registers are not reset.
// Outputs are zero when the root is zero and saturate to the word range.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int WORD_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [WORD_WIDTH-1:0] in_m00,
  input  wire logic signed [WORD_WIDTH-1:0] in_m01,
  input  wire logic signed [WORD_WIDTH-1:0] in_m02,
  input  wire logic signed [WORD_WIDTH-1:0] in_m10,
  input  wire logic signed [WORD_WIDTH-1:0] in_m11,
  input  wire logic signed [WORD_WIDTH-1:0] in_m12,
  input  wire logic signed [WORD_WIDTH-1:0] in_m20,
  input  wire logic signed [WORD_WIDTH-1:0] in_m21,
  input  wire logic signed [WORD_WIDTH-1:0] in_m22,
  output logic                              out_valid,
  output logic signed [WORD_WIDTH-1:0]      out_qx,
  output logic signed [WORD_WIDTH-1:0]      out_qy,
  output logic signed [WORD_WIDTH-1:0]      out_qz,
  output logic signed [WORD_WIDTH-1:0]      out_qw
);
  import rmq_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  // Root argument: up to 3*2^(W-1)+2^F, clamped non-negative.
  localparam int AW = W + 2;
  // Radicand a << F.
  localparam int RW = AW + F + 2;
  localparam int NB = RW / 2;
  localparam int SW = NB + 1;
  // Numerator magnitude (|d| << F) + s.
  localparam int DW = W + 2;
  localparam int NW = DW + F + 2;
  localparam int QB = NW;

  // Stage 0: register the input item.
  ctl_t ctl0_r;
  logic signed [W-1:0] m_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.vld <= 1'b0;
    end else begin
      ctl0_r.vld <= start;
    end
    ctl0_r.sel <= SEL_W;
    m_r[0] <= in_m00; m_r[1] <= in_m01; m_r[2] <= in_m02;
    m_r[3] <= in_m10; m_r[4] <= in_m11; m_r[5] <= in_m12;
    m_r[6] <= in_m20; m_r[7] <= in_m21; m_r[8] <= in_m22;
  end

  assign busy = 1'b0;

  // Stage 1: case selection, root argument and the three numerators.
  logic signed [AW-1:0] a00, a11, a22, tr, arg;
  logic signed [DW-1:0] dd0, dd1, dd2;
  sel_t sel;
  logic signed [DW-1:0] e01, e02, e10, e12, e20, e21;

  always_comb begin
    a00 = AW'(m_r[0]);
    a11 = AW'(m_r[4]);
    a22 = AW'(m_r[8]);
    e01 = DW'(m_r[1]); e02 = DW'(m_r[2]); e10 = DW'(m_r[3]);
    e12 = DW'(m_r[5]); e20 = DW'(m_r[6]); e21 = DW'(m_r[7]);
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      sel = SEL_W;
    end else if (a22 > ((a11 > a00) ? a11 : a00)) begin
      sel = SEL_Z;
    end else if (a11 > a00) begin
      sel = SEL_Y;
    end else begin
      sel = SEL_X;
    end
    case (sel)
      SEL_W: begin
        arg = tr + AW'(1 << F);
        dd0 = e12 - e21; dd1 = e20 - e02; dd2 = e01 - e10;
      end
      SEL_X: begin
        arg = a00 - (a11 + a22) + AW'(1 << F);
        dd0 = e10 + e01; dd1 = e20 + e02; dd2 = e12 - e21;
      end
      SEL_Y: begin
        arg = a11 - (a22 + a00) + AW'(1 << F);
        dd0 = e10 + e01; dd1 = e12 + e21; dd2 = e20 - e02;
      end
      default: begin
        arg = a22 - (a00 + a11) + AW'(1 << F);
        dd0 = e20 + e02; dd1 = e21 + e12; dd2 = e01 - e10;
      end
    endcase
  end

  ctl_t ctl1_r;
  logic [RW-1:0] rad1_r;
  logic signed [DW-1:0] d0_1_r, d1_1_r, d2_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
    end else begin
      ctl1_r.vld <= ctl0_r.vld;
    end
    ctl1_r.sel <= sel;
    rad1_r <= arg[AW-1] ? '0 : (RW'(arg[AW-2:0]) << F);
    d0_1_r <= dd0;
    d1_1_r <= dd1;
    d2_1_r <= dd2;
  end

  // Square root chain, one cell per result bit, from the top bit down.
  ctl_t ctl_s [NB+1];
  logic [RW-1:0] rem_s [NB+1];
  logic [RW-1:0] res_s [NB+1];
  logic signed [DW-1:0] d0_s [NB+1], d1_s [NB+1], d2_s [NB+1];
  ctl_t ctl_sq [NB];

  assign ctl_s[0] = ctl1_r;
  assign rem_s[0] = rad1_r;
  assign res_s[0] = '0;
  assign d0_s[0] = d0_1_r;
  assign d1_s[0] = d1_1_r;
  assign d2_s[0] = d2_1_r;

  for (genvar g = 0; g < NB; g++) begin : g_sqrt
    rmq_sqrt_cell #(.RW(RW), .DW(DW), .K(NB-1-g)) u_cell (
      .clk(clk), .ctl_i(ctl_s[g]), .rem_i(rem_s[g]), .res_i(res_s[g]),
      .d0_i(d0_s[g]), .d1_i(d1_s[g]), .d2_i(d2_s[g]),
      .ctl_o(ctl_sq[g]), .rem_o(rem_s[g+1]), .res_o(res_s[g+1]),
      .d0_o(d0_s[g+1]), .d1_o(d1_s[g+1]), .d2_o(d2_s[g+1])
    );
    // Valid bits are cleared by reset in every cell.
    always_comb begin
      ctl_s[g+1] = ctl_sq[g];
      if (!rst_n) ctl_s[g+1].vld = 1'b0;
    end
  end

  // Divider setup: magnitudes, signs and the rounding bias.
  logic [SW-1:0] s_root;
  logic [NW-1:0] num [3];
  logic [2:0] neg_v;
  logic signed [DW-1:0] dv [3];

  always_comb begin
    s_root = res_s[NB][SW-1:0];
    dv[0] = d0_s[NB]; dv[1] = d1_s[NB]; dv[2] = d2_s[NB];
    for (int i = 0; i < 3; i++) begin
      neg_v[i] = dv[i][DW-1];
      num[i] = (NW'(neg_v[i] ? -dv[i] : dv[i]) << F) + NW'(s_root);
    end
  end

  ctl_t ctl_d [QB+1];
  ctl_t ctl_dq [QB];
  logic [SW-1:0] s_d [QB+1];
  logic [2:0] neg_d [QB+1];
  logic [NW-1:0] n0_d [QB+1], n1_d [QB+1], n2_d [QB+1];
  logic [NW-1:0] q0_d [QB+1], q1_d [QB+1], q2_d [QB+1];

  assign ctl_d[0] = ctl_s[NB];
  assign s_d[0] = s_root;
  assign neg_d[0] = neg_v;
  assign n0_d[0] = num[0];
  assign n1_d[0] = num[1];
  assign n2_d[0] = num[2];
  assign q0_d[0] = '0;
  assign q1_d[0] = '0;
  assign q2_d[0] = '0;

  // Divider chain, one quotient bit per cell, from the top bit down.
  for (genvar g = 0; g < QB; g++) begin : g_div
    rmq_div_cell #(.NW(NW), .SW(SW), .K(QB-1-g)) u_cell (
      .clk(clk), .ctl_i(ctl_d[g]), .s_i(s_d[g]), .neg_i(neg_d[g]),
      .n0_i(n0_d[g]), .n1_i(n1_d[g]), .n2_i(n2_d[g]),
      .q0_i(q0_d[g]), .q1_i(q1_d[g]), .q2_i(q2_d[g]),
      .ctl_o(ctl_dq[g]), .s_o(s_d[g+1]), .neg_o(neg_d[g+1]),
      .n0_o(n0_d[g+1]), .n1_o(n1_d[g+1]), .n2_o(n2_d[g+1]),
      .q0_o(q0_d[g+1]), .q1_o(q1_d[g+1]), .q2_o(q2_d[g+1])
    );
    always_comb begin
      ctl_d[g+1] = ctl_dq[g];
      if (!rst_n) ctl_d[g+1].vld = 1'b0;
    end
  end

  // Output stage: apply signs, saturate, place components.
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [NW-1:0] qv [3];
  logic signed [W-1:0] qs [3];
  logic signed [W-1:0] root_half;
  logic signed [W-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic [SW:0] s_half;
  logic [SW-1:0] s_f;

  always_comb begin
    s_f = s_d[QB];
    qv[0] = q0_d[QB]; qv[1] = q1_d[QB]; qv[2] = q2_d[QB];
    for (int i = 0; i < 3; i++) begin
      if (neg_d[QB][i]) begin
        if (qv[i] >= NW'({1'b1, {(W-1){1'b0}}})) qs[i] = SMIN;
        else qs[i] = -W'(qv[i]);
      end else begin
        if (qv[i] > NW'(SMAX)) qs[i] = SMAX;
        else qs[i] = W'(qv[i]);
      end
    end
    s_half = ({1'b0, s_f} + 1'b1) >> 1;
    root_half = (s_half > (SW+1)'(SMAX)) ? SMAX : W'(s_half);
    case (ctl_d[QB].sel)
      SEL_X: begin qx_nxt = root_half; qy_nxt = qs[0]; qz_nxt = qs[1]; qw_nxt = qs[2]; end
      SEL_Y: begin qy_nxt = root_half; qx_nxt = qs[0]; qz_nxt = qs[1]; qw_nxt = qs[2]; end
      SEL_Z: begin qz_nxt = root_half; qx_nxt = qs[0]; qy_nxt = qs[1]; qw_nxt = qs[2]; end
      default: begin qw_nxt = root_half; qx_nxt = qs[0]; qy_nxt = qs[1]; qz_nxt = qs[2]; end
    endcase
    if (s_f == '0) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    end
  end

  logic valid_r;
  logic signed [W-1:0] qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_d[QB].vld;
    end
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    qz_r <= qz_nxt;
    qw_r <= qw_nxt;
  end

  assign out_valid = valid_r;
  assign out_qx = qx_r;
  assign out_qy = qy_r;
  assign out_qz = qz_r;
  assign out_qw = qw_r;
endmodule
`default_nettype wire

>>> rtl/core/rmq_checker.sv
// Port-level checker for the rotation matrix to quaternion block.
// Uses assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"
module rmq_port_checker #(
  parameter int WORD_WIDTH = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [WORD_WIDTH-1:0] out_qx,
  input wire logic [WORD_WIDTH-1:0] out_qy,
  input wire logic [WORD_WIDTH-1:0] out_qz,
  input wire logic [WORD_WIDTH-1:0] out_qw
);
  // The block never refuses an item.
  `ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")
  // Nothing comes out right after reset.
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result after reset")
  // A delivered result carries no unknown bits.
  `ASSERT_IMPL(a_no_x, clk, rst_n, out_valid |-> !$isunknown(out_qx ^ out_qy ^ out_qz ^ out_qw),
    "unknown result")
endmodule

bind rotation_matrix_to_quaternion rmq_port_checker #(.WORD_WIDTH(WORD_WIDTH)) u_rmq_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz), .out_qw(out_qw)
);
`default_nettype wire

>>> verif/rmq_checker.sv
// Checker for the rotation matrix to quaternion block: predicts each result
// from the accepted matrix and compares it with what the block delivers.
// Depends only on the block's port widths; no package types are needed.
module rmq_checker #(
  parameter int WORD_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [WORD_WIDTH-1:0] m00, m01, m02,
  input  logic signed [WORD_WIDTH-1:0] m10, m11, m12,
  input  logic signed [WORD_WIDTH-1:0] m20, m21, m22,
  input  logic                         out_valid,
  input  logic signed [WORD_WIDTH-1:0] out_qx, out_qy, out_qz, out_qw,
  output int                           fail_count,
  output int                           pending,
  output int                           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef struct {
    word_t qx, qy, qz, qw;
  } quat_t;

  localparam longint SAT_HI = (64'sd1 <<< (WORD_WIDTH - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  quat_t quat_q[$];

  // Integer square root, one result bit per step.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned root_q(longint a);
    if (a <= 0) return 0;
    return int_sqrt(longint'(a) << FRAC_BITS);
  endfunction

  // d * 0.5 / s rounded to nearest, halves away from zero.
  function automatic longint half_over_root(longint d, longint unsigned s);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = ((mag << FRAC_BITS) + s) / (2 * s);
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic word_t clip(longint v);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return word_t'(v);
  endfunction

  // Shepperd's method: pick the best-conditioned component for the root.
  function automatic quat_t matrix_to_quat(longint a00, longint a01, longint a02,
                                           longint a10, longint a11, longint a12,
                                           longint a20, longint a21, longint a22);
    longint one, tr, x, y, z, w;
    longint unsigned s;
    int pick;
    quat_t r;
    one = 64'sd1 <<< FRAC_BITS;
    tr  = a00 + a11 + a22;
    x = 0; y = 0; z = 0; w = 0;
    if (tr > 0) begin
      s = root_q(tr + one);
      if (s != 0) begin
        w = (s + 1) >> 1;
        x = half_over_root(a12 - a21, s);
        y = half_over_root(a20 - a02, s);
        z = half_over_root(a01 - a10, s);
      end
    end else begin
      pick = 0;
      if (a11 > a00) pick = 1;
      if (a22 > ((pick == 1) ? a11 : a00)) pick = 2;
      if (pick == 0) begin
        s = root_q(a00 - (a11 + a22) + one);
        if (s != 0) begin
          x = (s + 1) >> 1;
          y = half_over_root(a10 + a01, s);
          z = half_over_root(a20 + a02, s);
          w = half_over_root(a12 - a21, s);
        end
      end else if (pick == 1) begin
        s = root_q(a11 - (a22 + a00) + one);
        if (s != 0) begin
          y = (s + 1) >> 1;
          x = half_over_root(a10 + a01, s);
          z = half_over_root(a12 + a21, s);
          w = half_over_root(a20 - a02, s);
        end
      end else begin
        s = root_q(a22 - (a00 + a11) + one);
        if (s != 0) begin
          z = (s + 1) >> 1;
          x = half_over_root(a20 + a02, s);
          y = half_over_root(a21 + a12, s);
          w = half_over_root(a01 - a10, s);
        end
      end
    end
    r.qx = clip(x);
    r.qy = clip(y);
    r.qz = clip(z);
    r.qw = clip(w);
    return r;
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  // Record each accepted matrix and check each delivered quaternion.
  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n && start && !busy)
      quat_q.push_back(matrix_to_quat(m00, m01, m02, m10, m11, m12, m20, m21, m22));
    if (rst_n && out_valid) begin
      results_seen++;
      got.qx = out_qx; got.qy = out_qy; got.qz = out_qz; got.qw = out_qw;
      if (quat_q.size() == 0) begin
        $error("quaternion delivered with no matrix waiting");
        fail_count++;
      end else begin
        want = quat_q.pop_front();
        if (got.qx !== want.qx) begin
          $error("qx: expected %0d, got %0d", want.qx, got.qx); fail_count++;
        end
        if (got.qy !== want.qy) begin
          $error("qy: expected %0d, got %0d", want.qy, got.qy); fail_count++;
        end
        if (got.qz !== want.qz) begin
          $error("qz: expected %0d, got %0d", want.qz, got.qz); fail_count++;
        end
        if (got.qw !== want.qw) begin
          $error("qw: expected %0d, got %0d", want.qw, got.qw); fail_count++;
        end
      end
    end
    pending = quat_q.size();
  end
endmodule

>>> verif/tb_top.sv
// Testbench top for the rotation matrix to quaternion block.
// Drives directed and random matrices; depends on rmq_checker and the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W      = 16;
  localparam int F      = 14;
  localparam int ONE    = 1 << F;
  localparam int LAT    = 54;
  localparam int N_RAND = 1600;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [W-1:0] word_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy, out_valid;
  word_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
  word_t m12 = '0, m20 = '0, m21 = '0, m22 = '0;
  word_t out_qx, out_qy, out_qz, out_qw;
  logic  took = 1'b0;
  int    fail_count, pending, results_seen;
  int    idle_gap_cycles = 0;
  int    quiet_cycles = 0;

  always #10 clk = ~clk;

  rotation_matrix_to_quaternion #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m00(m00), .in_m01(m01), .in_m02(m02),
    .in_m10(m10), .in_m11(m11), .in_m12(m12),
    .in_m20(m20), .in_m21(m21), .in_m22(m22),
    .out_valid(out_valid), .out_qx(out_qx), .out_qy(out_qy),
    .out_qz(out_qz), .out_qw(out_qw)
  );

  rmq_checker #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .out_valid(out_valid), .out_qx(out_qx), .out_qy(out_qy),
    .out_qz(out_qz), .out_qw(out_qw),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // Note whether an item was taken at this edge.
  always @(posedge clk) took <= rst_n && start && !busy;

  // Watchdog: end the run after too long without any item moving.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one matrix, with random idle cycles ahead of it when allowed.
  // Called at a falling edge; returns at the falling edge after the item
  // was taken, with start still high so the next item can follow at once.
  task automatic send_matrix(input word_t e[9], input bit may_idle);
    while (may_idle && $urandom_range(99) < 12) begin
      start <= 1'b0;
      idle_gap_cycles++;
      @(negedge clk);
    end
    start <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    do @(negedge clk); while (!took);
  endtask

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  initial begin
    word_t e[9];
    int kind;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: identity, half turns, a quarter turn, extremes, ties and near-zero roots.
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send_matrix(e, 0);
    e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};          send_matrix(e, 0);
    e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};          send_matrix(e, 0);
    e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};          send_matrix(e, 0);
    e = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};           send_matrix(e, 0);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(e, 0);
    e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};         send_matrix(e, 0);
    foreach (e[i]) e[i] = 16'sh7fff;                   send_matrix(e, 0);
    foreach (e[i]) e[i] = 16'sh8000;                   send_matrix(e, 0);
    e = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; send_matrix(e, 0);
    e = '{1, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 16'sh7fff,
          16'sh7fff, 16'sh8000, 0};                    send_matrix(e, 0);
    e = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, -ONE + 1,
          16'sh8000, 16'sh7fff, 16'sh7fff, -1};        send_matrix(e, 0);
    e = '{-ONE + 1, 16'sh7fff, 16'sh7fff, 16'sh8000, 0,
          16'sh7fff, 16'sh8000, 16'sh8000, -ONE + 1};  send_matrix(e, 0);
    e = '{5, 100, -100, 200, 5, 300, -300, 400, 5};    send_matrix(e, 0);
    e = '{1, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 16'sh8000,
          16'sh7fff, 16'sh7fff, -1};                   send_matrix(e, 0);

    // Random: full range, unit range, diagonal-dominant and near-rotation matrices.
    for (int n = 0; n < N_RAND; n++) begin
      kind = $urandom_range(3);
      foreach (e[i]) begin
        if (kind == 0) e[i] = rand_word();
        else e[i] = word_t'($signed($urandom_range(2 * ONE)) - ONE);
      end
      if (kind == 2) begin
        e[4 * $urandom_range(2)] = word_t'($urandom_range(ONE + 2000, ONE - 2000));
      end else if (kind == 3) begin
        e[0] = $urandom_range(1) ? word_t'(ONE) : word_t'(-ONE);
        e[4] = $urandom_range(1) ? word_t'(ONE) : word_t'(-ONE);
        e[8] = $urandom_range(1) ? word_t'(ONE) : word_t'(-ONE);
      end
      // Let the pipeline drain completely once mid-run.
      if (n == 700) begin
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      send_matrix(e, !(n >= 800 && n < 1100));
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("covered %0d matrices in all three root cases and the trace case,",
             N_RAND + 15);
    $display("with %0d idle cycles on the input and one full drain mid-run",
             idle_gap_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rmq_pkg.sv
rtl/core/rmq_sqrt_cell.sv
rtl/core/rmq_div_cell.sv
rtl/core/rotation_matrix_to_quaternion.sv
rtl/core/rmq_checker.sv
verif/rmq_checker.sv
verif/tb_top.sv
